### hdl/quadratic_root_solver_unit_macros.svh
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_macros
// assertion macros for the quadratic root solver
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QRS_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("quadratic root solver check failed");

// next-cycle implication, checked outside reset
`define QRS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("quadratic root solver check failed");

`endif

### hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// types, widths and codes shared by the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // square root result bits, radicand width
  localparam int ROOT_BITS = WORD_BITS + FRAC_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  // quotient numerator magnitude and denominator widths
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS + 2;
  localparam int DEN_BITS  = WORD_BITS + 1;

  typedef enum logic [2:0] {
    KIND_DISTINCT,
    KIND_REPEATED,
    KIND_COMPLEX,
    KIND_LINEAR,
    KIND_DEGENERATE
  } root_kind_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    root_kind_t                  root_kind;
    logic signed [WORD_BITS-1:0] first_value;
    logic signed [WORD_BITS-1:0] second_value;
    logic                        overflow;
  } root_t;

endpackage

### hdl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// pipelined restoring divider, one quotient bit per stage, unsigned
// ----------------------------------------------------------------------------
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NUM_W = NUM_BITS,
  parameter int DEN_W = DEN_BITS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] n [0:NUM_W];
  logic [DEN_W-1:0] r [0:NUM_W];
  logic [DEN_W-1:0] d [0:NUM_W];
  logic [NUM_W-1:0] q [0:NUM_W];

  assign n[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign q[0] = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] rr;
    logic           ge;
    logic [DEN_W:0] diff;

    always_comb begin
      rr   = {r[k], n[k][NUM_W-1]};
      ge   = rr >= {1'b0, d[k]};
      diff = rr - {1'b0, d[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1] <= n[k] << 1;
        r[k+1] <= ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
        d[k+1] <= d[k];
        q[k+1] <= {q[k][NUM_W-2:0], ge};
      end
    end
  end

  assign quo = q[NUM_W];

endmodule

### hdl/quadratic_root_solver_unit.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// roots of a*x^2 + b*x + c = 0 in signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel  payload  valid       stall       role
//  coef     coef_t   coef_valid  coef_stall  coefficient set in
//  root     root_t   root_valid  root_stall  kind, roots, overflow out
//
//  one transaction per cycle while the output is not stalled; words are
//  Q16.16, and the bit-per-stage square root and dividers set the depth
//  a stall while root_valid is high freezes every stage; the input stalls with it
//  synchronous reset clears the valid bits only
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_macros.svh"

module quadratic_root_solver_unit
  import qrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  coef_valid,
  output logic  coef_stall,
  input  coef_t coef,
  output logic  root_valid,
  input  logic  root_stall,
  output root_t root
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W + 3;

  typedef struct packed {
    root_kind_t                kind;
    logic signed [NUM_BITS:0]  base;
    logic [DEN_BITS-1:0]       den;
    logic                      den_neg;
  } side_t;

  typedef struct packed {
    root_kind_t kind;
    logic       q1_neg;
    logic       q2_neg;
  } qside_t;

  logic en;
  assign en         = !(root_valid && root_stall);
  assign coef_stall = !en;

  // stage 1: sign and magnitude
  logic         s1_v;
  logic         s1_an, s1_bn, s1_cn;
  logic [W-1:0] s1_am, s1_bm, s1_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_an <= coef.coef_a[W-1];
      s1_bn <= coef.coef_b[W-1];
      s1_cn <= coef.coef_c[W-1];
      s1_am <= coef.coef_a[W-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
      s1_bm <= coef.coef_b[W-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
      s1_cm <= coef.coef_c[W-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;
    end
  end

  // stage 2: products
  logic           s2_v;
  logic           s2_an, s2_bn, s2_cn;
  logic [W-1:0]   s2_am, s2_bm, s2_cm;
  logic [2*W-1:0] s2_bb, s2_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_an <= s1_an;
      s2_bn <= s1_bn;
      s2_cn <= s1_cn;
      s2_am <= s1_am;
      s2_bm <= s1_bm;
      s2_cm <= s1_cm;
      s2_bb <= s1_bm * s1_bm;
      s2_ac <= s1_am * s1_cm;
    end
  end

  // stage 3: discriminant, kind, numerator base, denominator
  logic signed [DW-1:0]     dval;
  logic [DW-1:0]            dabs;
  logic signed [NUM_BITS:0] nb, nc;
  logic [NUM_BITS:0]        bsh, csh;
  side_t                    s3_side;

  always_comb begin
    dval = (s2_an == s2_cn) ? $signed({3'b000, s2_bb} - {1'b0, s2_ac, 2'b00})
                            : $signed({3'b000, s2_bb} + {1'b0, s2_ac, 2'b00});
    dabs = dval[DW-1] ? (~dval + 1'b1) : dval;
    bsh  = {{(NUM_BITS+1-W-F){1'b0}}, s2_bm, {F{1'b0}}};
    csh  = {{(NUM_BITS+1-W-F){1'b0}}, s2_cm, {F{1'b0}}};
    nb   = s2_bn ? $signed(bsh) : -$signed(bsh);
    nc   = s2_cn ? $signed(csh) : -$signed(csh);
    s3_side.base    = nb;
    s3_side.den     = {s2_am, 1'b0};
    s3_side.den_neg = s2_an;
    if (s2_am == '0) begin
      s3_side.kind    = (s2_bm == '0) ? KIND_DEGENERATE : KIND_LINEAR;
      s3_side.base    = nc;
      s3_side.den     = {1'b0, s2_bm};
      s3_side.den_neg = s2_bn;
    end else if (dabs == '0) begin
      s3_side.kind = KIND_REPEATED;
    end else if (dval[DW-1]) begin
      s3_side.kind = KIND_COMPLEX;
    end else begin
      s3_side.kind = KIND_DISTINCT;
    end
  end

  // square root pipeline, one root bit per stage
  logic                  sq_v [0:ROOT_BITS];
  side_t                 sq_s [0:ROOT_BITS];
  logic [RAD_BITS-1:0]   sq_x [0:ROOT_BITS];
  logic [ROOT_BITS:0]    sq_r [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]  sq_q [0:ROOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s[0] <= s3_side;
      sq_x[0] <= {{(RAD_BITS-2*W-1-2*F){1'b0}}, dabs[2*W:0], {(2*F){1'b0}}};
      sq_r[0] <= '0;
      sq_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    logic [ROOT_BITS+2:0] rr, trial, diff;
    logic                 ge;

    always_comb begin
      rr    = {sq_r[k], sq_x[k][RAD_BITS-1 -: 2]};
      trial = {1'b0, sq_q[k], 2'b01};
      ge    = rr >= trial;
      diff  = rr - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s[k+1] <= sq_s[k];
        sq_x[k+1] <= sq_x[k] << 2;
        sq_r[k+1] <= ge ? diff[ROOT_BITS:0] : rr[ROOT_BITS:0];
        sq_q[k+1] <= {sq_q[k][ROOT_BITS-2:0], ge};
      end
    end
  end

  // stage 4: numerators and quotient signs
  side_t                    ts;
  logic signed [NUM_BITS:0] sqs, n1, n2;
  logic                     s4_v;
  qside_t                   s4_side;
  logic [NUM_BITS-1:0]      s4_n1, s4_n2;
  logic [DEN_BITS-1:0]      s4_den;

  always_comb begin
    ts  = sq_s[ROOT_BITS];
    sqs = $signed({{(NUM_BITS+1-ROOT_BITS){1'b0}}, sq_q[ROOT_BITS]});
    n1  = ts.base;
    n2  = ts.base;
    unique case (ts.kind)
      KIND_DISTINCT: begin
        n1 = ts.base + sqs;
        n2 = ts.base - sqs;
      end
      KIND_COMPLEX: begin
        n2 = sqs;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= sq_v[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.kind   <= ts.kind;
      s4_side.q1_neg <= n1[NUM_BITS] ^ ts.den_neg;
      s4_side.q2_neg <= n2[NUM_BITS] ^ (ts.den_neg && ts.kind != KIND_COMPLEX);
      s4_n1          <= n1[NUM_BITS] ? NUM_BITS'(-n1) : n1[NUM_BITS-1:0];
      s4_n2          <= n2[NUM_BITS] ? NUM_BITS'(-n2) : n2[NUM_BITS-1:0];
      s4_den         <= ts.den;
    end
  end

  // dividers and aligned sideband
  logic [NUM_BITS-1:0] quo1, quo2;
  logic                dv_v [0:NUM_BITS];
  qside_t              dv_s [0:NUM_BITS];

  qrs_div #(.NUM_W(NUM_BITS), .DEN_W(DEN_BITS)) u_div1 (
    .clk (clk), .en (en), .num (s4_n1), .den (s4_den), .quo (quo1)
  );

  qrs_div #(.NUM_W(NUM_BITS), .DEN_W(DEN_BITS)) u_div2 (
    .clk (clk), .en (en), .num (s4_n2), .den (s4_den), .quo (quo2)
  );

  assign dv_v[0] = s4_v;
  assign dv_s[0] = s4_side;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[k+1] <= dv_s[k];
      end
    end
  end

  // output stage: saturation
  function automatic logic [W:0] saturate(input logic [NUM_BITS-1:0] q, input logic neg);
    logic [NUM_BITS-1:0] half, lim, mag;
    logic                big;
    logic [W-1:0]        val;
    half = NUM_BITS'(1) << (W - 1);
    lim  = neg ? half : half - 1'b1;
    big  = q > lim;
    mag  = big ? lim : q;
    val  = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
    return {big, val};
  endfunction

  qside_t     fs;
  logic [W:0] sat1, sat2;
  root_t      res;

  always_comb begin
    fs   = dv_s[NUM_BITS];
    sat1 = saturate(quo1, fs.q1_neg);
    sat2 = saturate(quo2, fs.q2_neg);
    res.root_kind    = fs.kind;
    res.first_value  = sat1[W-1:0];
    res.second_value = sat2[W-1:0];
    res.overflow     = sat1[W] | sat2[W];
    unique case (fs.kind)
      KIND_LINEAR: begin
        res.second_value = '0;
        res.overflow     = sat1[W];
      end
      KIND_DEGENERATE: begin
        res.first_value  = '0;
        res.second_value = '0;
        res.overflow     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= dv_v[NUM_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= res;
    end
  end

  `QRS_ASSERT_NOW(a_stall_follows_output, 1'b1, coef_stall == (root_valid && root_stall))
  `QRS_ASSERT_NEXT(a_held_when_stalled, root_valid && root_stall, root_valid && $stable(root))
  `QRS_ASSERT_NOW(a_degenerate_zero,
                  root_valid && root.root_kind == KIND_DEGENERATE,
                  root.first_value == '0 && root.second_value == '0 && !root.overflow)
  `QRS_ASSERT_NOW(a_imag_non_negative,
                  root_valid && root.root_kind == KIND_COMPLEX,
                  !root.second_value[W-1])

endmodule

### bench/quadratic_root_solver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_tb
// self-checking bench for the fixed-point quadratic root solver
//
// coefficient sets go in through the valid/stall channel and the roots are
// predicted in wide signed arithmetic, then compared in order with every
// transaction on the root channel; directed corner cases come first, then
// random sets weighted toward each root kind, with random gaps on both
// sides, a long output hold-off and a pause until the pipeline is empty
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int LIMIT   = 1000000;
  localparam int LATENCY = 120;

  typedef logic signed [127:0] wide_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  coef_valid = 1'b0;
  logic  coef_stall;
  coef_t coef = '0;
  logic  root_valid;
  logic  root_stall = 1'b0;
  root_t root;

  root_t expected_roots[$];
  int    errors = 0;
  int    cycles = 0;
  int    sent = 0;
  int    checked = 0;
  int    kind_seen[5];
  int    hold_left = 0;
  int    stall_left = 0;
  int    stall_pct = 20;

  quadratic_root_solver_unit i_dut (
    .clk(clk),
    .rst(rst),
    .coef_valid(coef_valid),
    .coef_stall(coef_stall),
    .coef(coef),
    .root_valid(root_valid),
    .root_stall(root_stall),
    .root(root)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic wide_t int_sqrt(wide_t x);
    wide_t r, t;
    r = 0;
    for (int i = 55; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] clamp(wide_t q, ref logic ovf);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (q > hi) begin
      ovf = 1'b1;
      return hi[WORD_BITS-1:0];
    end
    if (q < lo) begin
      ovf = 1'b1;
      return lo[WORD_BITS-1:0];
    end
    return q[WORD_BITS-1:0];
  endfunction

  function automatic root_t solve_roots(coef_t c);
    wide_t a, b, k, disc, root_s, den, nb;
    root_t r;
    logic  ovf;
    a = c.coef_a;
    b = c.coef_b;
    k = c.coef_c;
    ovf = 1'b0;
    r = '0;
    r.root_kind = KIND_DEGENERATE;
    if (a != 0) begin
      disc = b * b - 4 * a * k;
      den = 2 * a;
      nb = -(b <<< FRAC_BITS);
      if (disc == 0) begin
        r.root_kind = KIND_REPEATED;
        r.first_value = clamp(nb / den, ovf);
        r.second_value = r.first_value;
      end else if (disc > 0) begin
        root_s = int_sqrt(disc <<< (2 * FRAC_BITS));
        r.root_kind = KIND_DISTINCT;
        r.first_value = clamp((nb + root_s) / den, ovf);
        r.second_value = clamp((nb - root_s) / den, ovf);
      end else begin
        root_s = int_sqrt((-disc) <<< (2 * FRAC_BITS));
        r.root_kind = KIND_COMPLEX;
        r.first_value = clamp(nb / den, ovf);
        r.second_value = clamp(root_s / (den < 0 ? -den : den), ovf);
      end
    end else if (b != 0) begin
      r.root_kind = KIND_LINEAR;
      r.first_value = clamp(-(k <<< FRAC_BITS) / b, ovf);
    end
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report(string field, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
    errors++;
    $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    root_t want;
    if (!rst && root_valid && !root_stall) begin
      if (expected_roots.size() == 0) begin
        errors++;
        $display("unexpected root transaction at cycle %0d", cycles);
      end else begin
        want = expected_roots.pop_front();
        checked++;
        kind_seen[want.root_kind]++;
        if (root.root_kind !== want.root_kind)
          report("root_kind", 32'(root.root_kind), 32'(want.root_kind));
        if (root.first_value !== want.first_value)
          report("first_value", root.first_value, want.first_value);
        if (root.second_value !== want.second_value)
          report("second_value", root.second_value, want.second_value);
        if (root.overflow !== want.overflow)
          report("overflow", 32'(root.overflow), 32'(want.overflow));
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_left > 0) begin
      root_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      root_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      root_stall <= 1'b1;
      stall_left = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
    end else begin
      root_stall <= 1'b0;
    end
  end

  task automatic send_coef(coef_t c, bit allow_gap = 1'b1);
    int gap;
    coef <= c;
    coef_valid <= 1'b1;
    do @(posedge clk); while (coef_stall);
    expected_roots.push_back(solve_roots(c));
    sent++;
    gap = 0;
    if (allow_gap) begin
      case ($urandom_range(19))
        0:       gap = $urandom_range(60, 20);
        1, 2, 3: gap = $urandom_range(3, 1);
        4, 5:    gap = 1;
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      coef_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_roots.size() > 0) @(posedge clk);
  endtask

  function automatic coef_t make_coef(int a, int b, int c);
    coef_t r;
    r.coef_a = a;
    r.coef_b = b;
    r.coef_c = c;
    return r;
  endfunction

  function automatic int rnd_signed(int span);
    int v;
    v = $urandom_range(span);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic coef_t random_coef();
    int a, m;
    case ($urandom_range(9))
      0, 1: return make_coef($urandom, $urandom, $urandom);
      2, 3: return make_coef(rnd_signed(1 << 20), rnd_signed(1 << 22), rnd_signed(1 << 22));
      4: return make_coef(rnd_signed(1 << 12), $urandom, rnd_signed(1 << 12));
      5: return make_coef(0, $urandom_range(1) ? $urandom : rnd_signed(1 << 16), $urandom);
      6: return make_coef(0, 0, $urandom_range(1) ? $urandom : 0);
      7, 8: begin
        a = rnd_signed(1000);
        if (a == 0) a = 1;
        m = rnd_signed(100);
        return make_coef(a, 2 * a * m, a * m * m);
      end
      default: return make_coef(rnd_signed(1 << 17), rnd_signed(1 << 17), rnd_signed(1 << 17));
    endcase
  endfunction

  task automatic test_directed();
    int one;
    one = 1 << FRAC_BITS;
    send_coef(make_coef(one, -3 * one, 2 * one));
    send_coef(make_coef(one, 2 * one, one));
    send_coef(make_coef(one, 0, one));
    send_coef(make_coef(-one, one, 6 * one));
    send_coef(make_coef(0, 2 * one, 4 * one));
    send_coef(make_coef(0, -one, 0));
    send_coef(make_coef(0, 0, 5 * one));
    send_coef(make_coef(0, 0, 0));
    send_coef(make_coef(1, 32'h7fffffff, 1));
    send_coef(make_coef(0, 1, 32'h7fffffff));
    send_coef(make_coef(0, 1, 32'h80000000));
    send_coef(make_coef(32'h80000000, 32'h80000000, 32'h80000000));
    send_coef(make_coef(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_coef(make_coef(32'h80000000, 0, 32'h7fffffff));
    send_coef(make_coef(32'h7fffffff, 32'h80000000, 32'h80000000));
    send_coef(make_coef(1, 0, 32'h80000000));
    send_coef(make_coef(-1, 0, 32'h80000000));
    send_coef(make_coef(32'hffffffff, 32'hffffffff, 32'hffffffff));
    send_coef(make_coef(0, 32'h80000000, 32'h80000000));
    send_coef(make_coef(one, 0, 0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 200) stall_pct = 0;
      if (i % 400 == 300) stall_pct = 20;
      send_coef(random_coef(), stall_pct != 0);
    end
  endtask

  task automatic test_output_hold();
    hold_left = 400;
    for (int i = 0; i < 150; i++) send_coef(random_coef(), 1'b0);
  endtask

  task automatic test_pause();
    for (int i = 0; i < 30; i++) send_coef(random_coef());
    coef_valid <= 1'b0;
    drain();
    for (int i = 0; i < 30; i++) send_coef(random_coef(), 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_hold();
    test_pause();
    test_random(1500);
    coef_valid <= 1'b0;
    drain();
    repeat (LATENCY) @(posedge clk);
    $display("%0d coefficient sets sent, %0d root transactions checked", sent, checked);
    $display("distinct %0d, repeated %0d, complex %0d, linear %0d, degenerate %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/qrs_pkg.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_unit.sv
bench/quadratic_root_solver_unit_tb.sv
